>>> design/ffra_pkg.sv
// shared types and constants of the first-fit resource map allocator
`timescale 1ns / 1ps

package ffra_pkg;

    localparam int ADDR_W = 21;
    localparam int SIZE_W = 14;
    localparam int LEN_W  = 32;
    localparam int CTR_W  = 32;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE  = 3'd1;
    localparam logic [2:0] ST_NO_PAGE    = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL = 3'd3;
    localparam logic [2:0] ST_POOL_RESET = 3'd4;

    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] block_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic [2:0]        status;
    } rsp_t;

    // one free segment of the table
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } seg_t;

endpackage

>>> design/ffra_seg_mem.sv
// segment table memory, one write and one registered read port
`timescale 1ns / 1ps

module ffra_seg_mem
    import ffra_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  seg_t                     wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output seg_t                     rdata
);

    seg_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/ffra_alu.sv
// shared add, subtract and compare unit
`timescale 1ns / 1ps

module ffra_alu
    import ffra_pkg::*;
(
    input  logic [LEN_W-1:0] a,
    input  logic [LEN_W-1:0] b,
    output logic [LEN_W-1:0] sum,
    output logic [LEN_W-1:0] diff,
    output logic             ge
);

    assign sum  = a + b;
    assign diff = a - b;
    assign ge   = (a >= b);

endmodule

>>> design/ffra_ctrl.sv
// sequencer that scans, shifts and merges the segment table
`timescale 1ns / 1ps

module ffra_ctrl
    import ffra_pkg::*;
#(
    parameter int PAGE_BYTES   = 8192,
    parameter int HEADER_BYTES = 32,
    parameter int MIN_BLOCK    = 16,
    parameter int MAX_SEGMENTS = 64,
    parameter int MAX_PAGES    = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  req_t                            req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output rsp_t                            rsp,
    output logic                            mem_we,
    output logic [$clog2(MAX_SEGMENTS)-1:0] mem_waddr,
    output seg_t                            mem_wdata,
    output logic                            mem_re,
    output logic [$clog2(MAX_SEGMENTS)-1:0] mem_raddr,
    input  seg_t                            mem_rdata
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int PG_W  = $clog2(MAX_PAGES + 1);
    localparam logic [LEN_W-1:0]  USABLE = LEN_W'(PAGE_BYTES - HEADER_BYTES);
    localparam logic [LEN_W-1:0]  MINB   = LEN_W'(MIN_BLOCK);
    localparam logic [SIZE_W-1:0] MINS   = SIZE_W'(MIN_BLOCK);

    typedef enum logic [3:0] {
        S_IDLE, S_A_SCAN, S_A_PAGE, S_POS_SCAN, S_F_PREV, S_F_NEXT,
        S_F_MERGE, S_F_WRITE, S_SHIFT_DN, S_SHIFT_UP, S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic                kind_reg, kind_next;
    logic [SIZE_W-1:0]   sz_reg, sz_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [ADDR_W-1:0]   tgt_reg, tgt_next;
    seg_t                ent_reg, ent_next;
    seg_t                prv_reg, prv_next;
    seg_t                nxt_reg, nxt_next;
    logic                has_next_reg, has_next_next;
    logic                prev_adj_reg, prev_adj_next;
    logic                next_adj_reg, next_adj_next;
    logic [LEN_W-1:0]    acc_reg, acc_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]    didx_reg, didx_next;
    logic                dv_reg, dv_next;
    logic [ADDR_W-1:0]   grant_reg, grant_next;
    logic [2:0]          status_reg, status_next;
    logic                inc_alloc_reg, inc_alloc_next;
    logic                inc_page_reg, inc_page_next;
    logic                inc_free_reg, inc_free_next;
    logic [CNT_W-1:0]    seg_count_reg, seg_count_next;
    logic [PG_W-1:0]     pages_reg, pages_next;
    logic [CTR_W-1:0]    alloc_reg, alloc_next;
    logic [CTR_W-1:0]    free_reg, free_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    logic [LEN_W-1:0]    alu_a, alu_b, alu_sum, alu_diff;
    logic                alu_ge;
    logic [SIZE_W-1:0]   sz_in;
    logic [ADDR_W-1:0]   page_base, page_grant, page_rest;
    logic [CTR_W-1:0]    free_inc;

    ffra_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .sum  (alu_sum),
        .diff (alu_diff),
        .ge   (alu_ge)
    );

    // size raised to the minimum block
    assign sz_in = (req.request_size < MINS) ? MINS : req.request_size;

    // addresses of the next page to open
    assign page_base  = ADDR_W'(ADDR_W'(pages_reg) * ADDR_W'(PAGE_BYTES));
    assign page_grant = page_base + ADDR_W'(HEADER_BYTES);
    assign page_rest  = page_grant + ADDR_W'(sz_reg);
    assign free_inc   = free_reg + CTR_W'(1);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        sz_next        = sz_reg;
        addr_next      = addr_reg;
        tgt_next       = tgt_reg;
        ent_next       = ent_reg;
        prv_next       = prv_reg;
        nxt_next       = nxt_reg;
        has_next_next  = has_next_reg;
        prev_adj_next  = prev_adj_reg;
        next_adj_next  = next_adj_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        rd_idx_next    = rd_idx_reg;
        didx_next      = didx_reg;
        dv_next        = dv_reg;
        grant_next     = grant_reg;
        status_next    = status_reg;
        inc_alloc_next = inc_alloc_reg;
        inc_page_next  = inc_page_reg;
        inc_free_next  = inc_free_reg;
        seg_count_next = seg_count_reg;
        pages_next     = pages_reg;
        alloc_next     = alloc_reg;
        free_next      = free_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        alu_a          = '0;
        alu_b          = '0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                alu_a = USABLE;
                alu_b = LEN_W'(sz_in);
                if (req_valid)
                begin
                    kind_next      = req.kind;
                    sz_next        = sz_in;
                    addr_next      = req.block_address;
                    tgt_next       = req.block_address;
                    grant_next     = '0;
                    status_next    = ST_OK;
                    inc_alloc_next = 1'b0;
                    inc_page_next  = 1'b0;
                    inc_free_next  = 1'b0;
                    rd_idx_next    = '0;
                    dv_next        = 1'b0;
                    if (req.kind == KIND_ALLOC)
                    begin
                        if (!alu_ge)
                        begin
                            status_next = ST_TOO_LARGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_A_SCAN;
                        end
                    end
                    else if (pages_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_POS_SCAN;
                    end
                end
            end

            // first segment whose length fits
            S_A_SCAN:
            begin
                alu_a = mem_rdata.len;
                alu_b = LEN_W'(sz_reg);
                if (dv_reg && alu_ge)
                begin
                    grant_next     = mem_rdata.start;
                    pos_next       = CNT_W'(didx_reg);
                    inc_alloc_next = 1'b1;
                    dv_next        = 1'b0;
                    if (alu_diff < MINB)
                    begin
                        state_next = S_SHIFT_DN;
                    end
                    else
                    begin
                        mem_we          = 1'b1;
                        mem_waddr       = didx_reg;
                        mem_wdata.start = mem_rdata.start + ADDR_W'(sz_reg);
                        mem_wdata.len   = alu_diff;
                        state_next      = S_DONE;
                    end
                end
                else if (rd_idx_reg == seg_count_reg)
                begin
                    state_next = S_A_PAGE;
                end
                else
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = rd_idx_reg[IDX_W-1:0];
                    didx_next   = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    dv_next     = 1'b1;
                end
            end

            // open a new page
            S_A_PAGE:
            begin
                alu_a = USABLE;
                alu_b = LEN_W'(sz_reg);
                if (pages_reg >= PG_W'(MAX_PAGES))
                begin
                    status_next = ST_NO_PAGE;
                    state_next  = S_DONE;
                end
                else if (alu_diff != '0 && seg_count_reg >= CNT_W'(MAX_SEGMENTS))
                begin
                    status_next = ST_TABLE_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    grant_next     = page_grant;
                    inc_alloc_next = 1'b1;
                    inc_page_next  = 1'b1;
                    if (alu_diff == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ent_next.start = page_rest;
                        ent_next.len   = alu_diff;
                        tgt_next       = page_rest;
                        rd_idx_next    = '0;
                        dv_next        = 1'b0;
                        state_next     = S_POS_SCAN;
                    end
                end
            end

            // first entry that starts above the target
            S_POS_SCAN:
            begin
                alu_a = LEN_W'(tgt_reg);
                alu_b = LEN_W'(mem_rdata.start);
                if ((dv_reg && !alu_ge) || rd_idx_reg == seg_count_reg)
                begin
                    if (dv_reg && !alu_ge)
                    begin
                        pos_next      = CNT_W'(didx_reg);
                        nxt_next      = mem_rdata;
                        has_next_next = 1'b1;
                    end
                    else
                    begin
                        pos_next      = seg_count_reg;
                        has_next_next = 1'b0;
                        if (dv_reg)
                        begin
                            prv_next = mem_rdata;
                        end
                    end
                    dv_next     = 1'b0;
                    rd_idx_next = seg_count_reg;
                    state_next  = (kind_reg == KIND_ALLOC) ? S_SHIFT_UP : S_F_PREV;
                end
                else
                begin
                    if (dv_reg)
                    begin
                        prv_next = mem_rdata;
                    end
                    mem_re      = 1'b1;
                    mem_raddr   = rd_idx_reg[IDX_W-1:0];
                    didx_next   = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    dv_next     = 1'b1;
                end
            end

            // previous segment ends at the freed block
            S_F_PREV:
            begin
                alu_a         = LEN_W'(prv_reg.start);
                alu_b         = prv_reg.len;
                prev_adj_next = (pos_reg != '0) && (alu_sum == LEN_W'(addr_reg));
                state_next    = S_F_NEXT;
            end

            // freed block ends at the next segment
            S_F_NEXT:
            begin
                alu_a         = LEN_W'(addr_reg);
                alu_b         = LEN_W'(sz_reg);
                next_adj_next = has_next_reg && (alu_sum == LEN_W'(nxt_reg.start));
                state_next    = S_F_MERGE;
            end

            S_F_MERGE:
            begin
                alu_a      = prev_adj_reg ? prv_reg.len : nxt_reg.len;
                alu_b      = LEN_W'(sz_reg);
                acc_next   = alu_sum;
                state_next = S_F_WRITE;
            end

            // merge or insert the freed block
            S_F_WRITE:
            begin
                alu_a         = acc_reg;
                alu_b         = nxt_reg.len;
                inc_free_next = 1'b1;
                dv_next       = 1'b0;
                if (prev_adj_reg)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = IDX_W'(pos_reg - CNT_W'(1));
                    mem_wdata.start = prv_reg.start;
                    if (next_adj_reg)
                    begin
                        mem_wdata.len = alu_sum;
                        rd_idx_next   = pos_reg + CNT_W'(1);
                        state_next    = S_SHIFT_DN;
                    end
                    else
                    begin
                        mem_wdata.len = acc_reg;
                        state_next    = S_DONE;
                    end
                end
                else if (next_adj_reg)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = pos_reg[IDX_W-1:0];
                    mem_wdata.start = addr_reg;
                    mem_wdata.len   = acc_reg;
                    state_next      = S_DONE;
                end
                else if (seg_count_reg >= CNT_W'(MAX_SEGMENTS))
                begin
                    status_next = ST_TABLE_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    ent_next.start = addr_reg;
                    ent_next.len   = LEN_W'(sz_reg);
                    rd_idx_next    = seg_count_reg;
                    state_next     = S_SHIFT_UP;
                end
            end

            // close the gap at pos, one entry a cycle
            S_SHIFT_DN:
            begin
                if (dv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = didx_reg - IDX_W'(1);
                    mem_wdata = mem_rdata;
                end
                if (rd_idx_reg < seg_count_reg)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = rd_idx_reg[IDX_W-1:0];
                    didx_next   = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    dv_next     = 1'b1;
                end
                else
                begin
                    dv_next        = 1'b0;
                    seg_count_next = seg_count_reg - CNT_W'(1);
                    state_next     = S_DONE;
                end
            end

            // open a gap at pos from the top down, then write the new entry
            S_SHIFT_UP:
            begin
                if (dv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = didx_reg + IDX_W'(1);
                    mem_wdata = mem_rdata;
                end
                if (rd_idx_reg > pos_reg)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = IDX_W'(rd_idx_reg - CNT_W'(1));
                    didx_next   = IDX_W'(rd_idx_reg - CNT_W'(1));
                    rd_idx_next = rd_idx_reg - CNT_W'(1);
                    dv_next     = 1'b1;
                end
                else if (dv_reg)
                begin
                    dv_next = 1'b0;
                end
                else
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = pos_reg[IDX_W-1:0];
                    mem_wdata      = ent_reg;
                    seg_count_next = seg_count_reg + CNT_W'(1);
                    state_next     = S_DONE;
                end
            end

            // update counters and hand the word to the output register
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next               = 1'b1;
                    rsp_next.granted_address     = grant_reg;
                    rsp_next.status              = status_reg;
                    if (inc_alloc_reg)
                    begin
                        alloc_next = alloc_reg + CTR_W'(1);
                    end
                    if (inc_page_reg)
                    begin
                        pages_next = pages_reg + PG_W'(1);
                    end
                    if (inc_free_reg)
                    begin
                        if (free_inc == alloc_reg)
                        begin
                            seg_count_next  = '0;
                            pages_next      = '0;
                            alloc_next      = '0;
                            free_next       = '0;
                            rsp_next.status = ST_POOL_RESET;
                        end
                        else
                        begin
                            free_next = free_inc;
                        end
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dv_reg        <= 1'b0;
            inc_alloc_reg <= 1'b0;
            inc_page_reg  <= 1'b0;
            inc_free_reg  <= 1'b0;
            seg_count_reg <= '0;
            pages_reg     <= '0;
            alloc_reg     <= '0;
            free_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dv_reg        <= dv_next;
            inc_alloc_reg <= inc_alloc_next;
            inc_page_reg  <= inc_page_next;
            inc_free_reg  <= inc_free_next;
            seg_count_reg <= seg_count_next;
            pages_reg     <= pages_next;
            alloc_reg     <= alloc_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        sz_reg       <= sz_next;
        addr_reg     <= addr_next;
        tgt_reg      <= tgt_next;
        ent_reg      <= ent_next;
        prv_reg      <= prv_next;
        nxt_reg      <= nxt_next;
        has_next_reg <= has_next_next;
        prev_adj_reg <= prev_adj_next;
        next_adj_reg <= next_adj_next;
        acc_reg      <= acc_next;
        pos_reg      <= pos_next;
        rd_idx_reg   <= rd_idx_next;
        didx_reg     <= didx_next;
        grant_reg    <= grant_next;
        status_reg   <= status_next;
        rsp_reg      <= rsp_next;
    end

endmodule

>>> design/first_fit_resource_map_allocator.sv
// top level of the first-fit resource map allocator
//
// A request word (kind, request_size, block_address) enters on req_valid /
// req_ready; one response word (granted_address, status) leaves on
// rsp_valid / rsp_ready for every request, in order.
// Allocate takes the first free segment that fits, or opens a new page.
// Free inserts the block in address order and merges it with neighbors;
// when frees catch up with allocations the whole pool is emptied.
// One request is worked on at a time; req_ready is high only when idle.
// A too-large allocate or a free with no page open skips the table.
// An allocate reads the entries in order up to the first that fits, and
// shifts the following entries down when that segment is used up. A page
// open or a free scans the table for the insert point and then shifts the
// entries above it, one table memory access a cycle.
// The response sits in an output register; a stalled receiver holds it,
// and the next request is still taken, finishing once the register frees.
// Reset empties the table and clears all counters at once; the table
// memory itself is not cleared, entries beyond the count are never read.
`timescale 1ns / 1ps

module first_fit_resource_map_allocator
    import ffra_pkg::*;
#(
    parameter int PAGE_BYTES   = 8192,
    parameter int HEADER_BYTES = 32,
    parameter int MIN_BLOCK    = 16,
    parameter int MAX_SEGMENTS = 64,
    parameter int MAX_PAGES    = 256
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    seg_t             mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    seg_t             mem_rdata;

    // sequencer
    ffra_ctrl #(
        .PAGE_BYTES   (PAGE_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MIN_BLOCK    (MIN_BLOCK),
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .MAX_PAGES    (MAX_PAGES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // segment table
    ffra_seg_mem #(
        .DEPTH (MAX_SEGMENTS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

>>> design/ffra_checker.sv
// port checks of the allocator and their binding to the top level
`timescale 1ns / 1ps

module ffra_checker
    import ffra_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // a waiting request word stays
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request word dropped or changed while waiting");

    // a stalled response word stays
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response word dropped or changed while stalled");

    // status is one of the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_TOO_LARGE ||
                       rsp.status == ST_NO_PAGE || rsp.status == ST_TABLE_FULL ||
                       rsp.status == ST_POOL_RESET))
    else $error("undefined status code");

    // responses with an error or pool-reset status grant nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.granted_address == '0)
    else $error("address granted with an error status");

    // a taken request leaves the block busy in the cycle after
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in progress");

endmodule

bind first_fit_resource_map_allocator ffra_checker u_ffra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
